// ----- rtl/core/btnctr_pkg.sv -----
// Shared types and constants for the button up/down counter with auto repeat.
// Holds the mode encoding, register defaults and the timing configuration bundle.
// No dependencies.
package btnctr_pkg;

   // Widths of the result fields and the timing registers
   localparam int DIGIT_W = 4;
   localparam int MODE_W  = 3;
   localparam int TICKS_W = 16;

   // Configuration port geometry: three 32-bit registers at 4-byte spacing
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register defaults after reset
   localparam logic [TICKS_W-1:0] IDLE_TICKS_RST   = 16'd1000;
   localparam logic [TICKS_W-1:0] HOLD_TICKS_RST   = 16'd300;
   localparam logic [TICKS_W-1:0] REPEAT_TICKS_RST = 16'd100;

   // Highest decimal digit
   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

   // Register index, taken from paddr[3:2]
   typedef enum logic [1:0] {
      CSR_IDLE   = 2'd0,
      CSR_HOLD   = 2'd1,
      CSR_REPEAT = 2'd2
   } csr_index_type;

   // Mode encoding as seen on the result channel
   typedef enum logic [MODE_W-1:0] {
      MODE_RELEASED = 3'd0,
      MODE_SLEEP    = 3'd1,
      MODE_RESET    = 3'd2,
      MODE_INC      = 3'd3,
      MODE_DEC      = 3'd4,
      MODE_INC_LONG = 3'd5,
      MODE_DEC_LONG = 3'd6
   } mode_type;

   // Timing registers as one bundle from the register file to the core
   typedef struct packed {
      logic [TICKS_W-1:0] idle_ticks;
      logic [TICKS_W-1:0] hold_ticks;
      logic [TICKS_W-1:0] repeat_ticks;
   } btnctr_cfg_type;

endpackage

// ----- rtl/core/btnctr_csr.sv -----
// Register file for the three timing registers behind an APB-style port.
// Depends on btnctr_pkg for widths, defaults and the register index codes.
module btnctr_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [btnctr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [btnctr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [btnctr_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                 csr_pready,
   output btnctr_pkg::btnctr_cfg_type           cfg
);
   import btnctr_pkg::*;

   logic [TICKS_W-1:0] idle_ff, idle_in;
   logic [TICKS_W-1:0] hold_ff, hold_in;
   logic [TICKS_W-1:0] rep_ff, rep_in;
   logic               wr_en;
   csr_index_type      idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign idx        = csr_index_type'(csr_paddr[3:2]);

   // Write decode; only the low 16 bits of the data are kept
   always_comb begin
      idle_in = idle_ff;
      hold_in = hold_ff;
      rep_in  = rep_ff;
      if (wr_en) begin
         unique case (idx)
            CSR_IDLE:   idle_in = csr_pwdata[TICKS_W-1:0];
            CSR_HOLD:   hold_in = csr_pwdata[TICKS_W-1:0];
            CSR_REPEAT: rep_in  = csr_pwdata[TICKS_W-1:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff <= IDLE_TICKS_RST;
         hold_ff <= HOLD_TICKS_RST;
         rep_ff  <= REPEAT_TICKS_RST;
      end else begin
         idle_ff <= idle_in;
         hold_ff <= hold_in;
         rep_ff  <= rep_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (idx)
         CSR_IDLE:   csr_prdata = {{(CSR_DATA_W-TICKS_W){1'b0}}, idle_ff};
         CSR_HOLD:   csr_prdata = {{(CSR_DATA_W-TICKS_W){1'b0}}, hold_ff};
         CSR_REPEAT: csr_prdata = {{(CSR_DATA_W-TICKS_W){1'b0}}, rep_ff};
         default:    csr_prdata = '0;
      endcase
   end

   assign cfg.idle_ticks   = idle_ff;
   assign cfg.hold_ticks   = hold_ff;
   assign cfg.repeat_ticks = rep_ff;

endmodule

// ----- rtl/core/btnctr_core.sv -----
// Mode machine, digit counter and one-shot tick timer; one update per step.
// The state registers double as the result register. Depends on btnctr_pkg.
module btnctr_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step_en,
   input  logic                                 rst_pressed,
   input  logic                                 inc_pressed,
   input  logic                                 dec_pressed,
   input  btnctr_pkg::btnctr_cfg_type           cfg,
   output logic [btnctr_pkg::DIGIT_W-1:0]       digit,
   output logic [btnctr_pkg::MODE_W-1:0]        mode
);
   import btnctr_pkg::*;

   mode_type           mode_ff, mode_in;
   logic [DIGIT_W-1:0] digit_ff, digit_in;
   logic [TICKS_W-1:0] timer_cnt_ff, timer_cnt_in;
   logic               timer_exp_ff, timer_exp_in;

   function automatic logic [DIGIT_W-1:0] step_up(input logic [DIGIT_W-1:0] d);
      return (d >= DIGIT_MAX) ? '0 : d + 1'b1;
   endfunction

   function automatic logic [DIGIT_W-1:0] step_down(input logic [DIGIT_W-1:0] d);
      return (d == '0 || d > DIGIT_MAX) ? DIGIT_MAX : d - 1'b1;
   endfunction

   // Next state: timer ticks down first, then the mode checks run in order,
   // a later check overriding an earlier one
   always_comb begin
      mode_in      = mode_ff;
      digit_in     = digit_ff;
      timer_cnt_in = timer_cnt_ff;
      timer_exp_in = timer_exp_ff;

      if (timer_cnt_in != '0) begin
         timer_cnt_in = timer_cnt_in - 1'b1;
         if (timer_cnt_in == '0) timer_exp_in = 1'b1;
      end

      unique case (mode_ff)
         MODE_RELEASED: begin
            if (rst_pressed) mode_in = MODE_RESET;
            if (inc_pressed) begin
               digit_in     = step_up(digit_in);
               timer_cnt_in = cfg.hold_ticks;
               timer_exp_in = 1'b0;
               mode_in      = MODE_INC;
            end
            if (dec_pressed) begin
               digit_in     = step_down(digit_in);
               timer_cnt_in = cfg.hold_ticks;
               timer_exp_in = 1'b0;
               mode_in      = MODE_DEC;
            end
            // stale expiry still sends us to sleep, even over a reset press
            if (timer_exp_in) begin
               mode_in      = MODE_SLEEP;
               timer_cnt_in = cfg.repeat_ticks;
               timer_exp_in = 1'b0;
            end
         end
         MODE_SLEEP: begin
            if (inc_pressed) begin
               digit_in     = step_up(digit_in);
               timer_cnt_in = cfg.hold_ticks;
               timer_exp_in = 1'b0;
               mode_in      = MODE_INC;
            end
            if (dec_pressed) begin
               digit_in     = step_down(digit_in);
               timer_cnt_in = cfg.hold_ticks;
               timer_exp_in = 1'b0;
               mode_in      = MODE_DEC;
            end
            // sleep countdown stops at zero
            if (timer_exp_in) begin
               if (digit_in != '0) digit_in = digit_in - 1'b1;
               timer_cnt_in = cfg.repeat_ticks;
               timer_exp_in = 1'b0;
            end
         end
         MODE_RESET: begin
            digit_in     = '0;
            timer_cnt_in = cfg.idle_ticks;
            timer_exp_in = 1'b0;
            mode_in      = MODE_RELEASED;
         end
         MODE_INC, MODE_INC_LONG: begin
            if (!inc_pressed) begin
               mode_in      = MODE_RELEASED;
               timer_cnt_in = cfg.idle_ticks;
               timer_exp_in = 1'b0;
            end
            if (timer_exp_in) begin
               digit_in     = step_up(digit_in);
               timer_cnt_in = cfg.repeat_ticks;
               timer_exp_in = 1'b0;
               mode_in      = MODE_INC_LONG;
            end
         end
         MODE_DEC, MODE_DEC_LONG: begin
            if (!dec_pressed) begin
               mode_in      = MODE_RELEASED;
               timer_cnt_in = cfg.idle_ticks;
               timer_exp_in = 1'b0;
            end
            if (timer_exp_in) begin
               digit_in     = step_down(digit_in);
               timer_cnt_in = cfg.repeat_ticks;
               timer_exp_in = 1'b0;
               mode_in      = MODE_DEC_LONG;
            end
         end
         default: ;
      endcase
   end

   // State and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_RELEASED;
         digit_ff     <= '0;
         timer_cnt_ff <= IDLE_TICKS_RST;
         timer_exp_ff <= 1'b0;
      end else if (step_en) begin
         mode_ff      <= mode_in;
         digit_ff     <= digit_in;
         timer_cnt_ff <= timer_cnt_in;
         timer_exp_ff <= timer_exp_in;
      end
   end

   assign digit = digit_ff;
   assign mode  = mode_ff;

   // Digit never leaves the decimal range
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      digit_ff <= DIGIT_MAX)
      else $error("digit out of range");

   // Expiry flag is only ever set with the counter at zero
   a_exp_zero: assert property (@(posedge clock) disable iff (reset)
      timer_exp_ff |-> (timer_cnt_ff == '0))
      else $error("timer expired with nonzero count");

   // A step out of the reset mode clears the digit and returns to released
   a_reset_clears: assert property (@(posedge clock) disable iff (reset)
      (step_en && mode_ff == MODE_RESET) |=> (digit_ff == '0 && mode_ff == MODE_RELEASED))
      else $error("reset mode did not clear digit");

   // State holds between steps
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> ($stable(digit_ff) && $stable(mode_ff)))
      else $error("state changed without a step");

endmodule

// ----- rtl/core/button_updown_counter_autorepeat.sv -----
// Up/down decimal digit counter on three debounced buttons, with long-press
// auto repeat and an idle sleep countdown. Each request is one scan tick
// carrying the reset, increment and decrement levels; each yields one result
// with the digit (0..9) and the mode after that tick. The block accepts one
// request per clock while req_stall is low; the input register is loaded at
// acceptance, then the mode/digit/timer register, which is also the result
// register, once that is free or draining. Timing is in ticks
// (requests), set by the idle, hold and repeat
// registers at byte addresses 0x0, 0x4 and 0x8; write them only while idle.
// Depends on btnctr_pkg, btnctr_csr and btnctr_core.
module button_updown_counter_autorepeat (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_reset_pressed,
   input  logic                                 req_inc_pressed,
   input  logic                                 req_dec_pressed,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [btnctr_pkg::DIGIT_W-1:0]       rsp_digit,
   output logic [btnctr_pkg::MODE_W-1:0]        rsp_mode,
   // configuration port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [btnctr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [btnctr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [btnctr_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                 csr_pready
);
   import btnctr_pkg::*;

   btnctr_cfg_type cfg;

   logic in_valid_ff, in_valid_in;
   logic in_rst_ff, in_inc_ff, in_dec_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_take;
   logic advance;

   btnctr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Input stage moves into the result register when that is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take)     in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request payload register
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_rst_ff <= req_reset_pressed;
         in_inc_ff <= req_inc_pressed;
         in_dec_ff <= req_dec_pressed;
      end
   end

   btnctr_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .rst_pressed (in_rst_ff),
      .inc_pressed (in_inc_ff),
      .dec_pressed (in_dec_ff),
      .cfg         (cfg),
      .digit       (rsp_digit),
      .mode        (rsp_mode)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- verif/button_updown_counter_autorepeat_tb.sv -----
// Self-checking testbench for the button up/down counter with auto repeat.
// Drives button ticks and timing registers, predicts digit and mode per tick.
// Depends on btnctr_pkg and the button_updown_counter_autorepeat RTL.
`timescale 1ns / 1ps

module button_updown_counter_autorepeat_tb;
   import btnctr_pkg::*;

   typedef struct packed {
      logic rst;
      logic inc;
      logic dec;
   } buttons_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      mode_type           mode;
   } digit_mode_type;

   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED_ADDR = 4'hC;
   localparam int NUM_PHASES = 12;
   localparam int PHASE_TICKS = 160;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_reset_pressed = 1'b0;
   logic                  req_inc_pressed = 1'b0;
   logic                  req_dec_pressed = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [DIGIT_W-1:0]    rsp_digit;
   logic [MODE_W-1:0]     rsp_mode;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   button_updown_counter_autorepeat dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted counter state and timing registers
   logic [TICKS_W-1:0] cfg_idle = IDLE_TICKS_RST;
   logic [TICKS_W-1:0] cfg_hold = HOLD_TICKS_RST;
   logic [TICKS_W-1:0] cfg_step = REPEAT_TICKS_RST;
   mode_type           ctr_mode = MODE_RELEASED;
   logic [DIGIT_W-1:0] ctr_digit = '0;
   logic [TICKS_W-1:0] ctr_timer = IDLE_TICKS_RST;
   logic               ctr_expired = 1'b0;

   buttons_type    pending_ticks[$];
   digit_mode_type expected_digit_mode[$];

   bit idle_on = 1'b1;
   bit rcv_hold = 1'b0;
   int send_gap = 0;
   int rcv_gap = 0;
   int fail_count = 0;
   int checked = 0;
   int settings_count = 0;
   int phase_count = 0;
   int mode_seen[0:7];

   function automatic void load_timer(input logic [TICKS_W-1:0] ticks);
      ctr_timer = ticks;
      ctr_expired = 1'b0;
   endfunction

   function automatic void count_up();
      ctr_digit = (ctr_digit >= DIGIT_MAX) ? '0 : ctr_digit + 1'b1;
   endfunction

   function automatic void count_down();
      ctr_digit = (ctr_digit == 0 || ctr_digit > DIGIT_MAX) ? DIGIT_MAX : ctr_digit - 1'b1;
   endfunction

   function automatic void take_presses(input logic inc, input logic dec);
      if (inc) begin
         count_up();
         load_timer(cfg_hold);
         ctr_mode = MODE_INC;
      end
      if (dec) begin
         count_down();
         load_timer(cfg_hold);
         ctr_mode = MODE_DEC;
      end
   endfunction

   // One scan tick: timer first, then the mode machine; later checks win
   function automatic void tick_counter(input logic rst, input logic inc, input logic dec);
      digit_mode_type r;
      if (ctr_timer != 0) begin
         ctr_timer = ctr_timer - 1'b1;
         if (ctr_timer == 0) ctr_expired = 1'b1;
      end
      case (ctr_mode)
         MODE_RELEASED: begin
            if (rst) ctr_mode = MODE_RESET;
            take_presses(inc, dec);
            if (ctr_expired) begin
               ctr_mode = MODE_SLEEP;
               load_timer(cfg_step);
            end
         end
         MODE_SLEEP: begin
            take_presses(inc, dec);
            if (ctr_expired) begin
               if (ctr_digit > 0) ctr_digit = ctr_digit - 1'b1;
               load_timer(cfg_step);
            end
         end
         MODE_RESET: begin
            ctr_digit = '0;
            load_timer(cfg_idle);
            ctr_mode = MODE_RELEASED;
         end
         MODE_INC, MODE_INC_LONG: begin
            if (!inc) begin
               ctr_mode = MODE_RELEASED;
               load_timer(cfg_idle);
            end
            if (ctr_expired) begin
               count_up();
               load_timer(cfg_step);
               ctr_mode = MODE_INC_LONG;
            end
         end
         MODE_DEC, MODE_DEC_LONG: begin
            if (!dec) begin
               ctr_mode = MODE_RELEASED;
               load_timer(cfg_idle);
            end
            if (ctr_expired) begin
               count_down();
               load_timer(cfg_step);
               ctr_mode = MODE_DEC_LONG;
            end
         end
         default: ;
      endcase
      r.digit = ctr_digit;
      r.mode = ctr_mode;
      expected_digit_mode.push_back(r);
   endfunction

   function automatic void note_failure(input string what);
      if (fail_count < 10) $display("ERROR at %0t: %s", $realtime, what);
      fail_count++;
   endfunction

   // Request driver: holds a stalled request, otherwise idles or sends the next tick
   always @(posedge clock) begin
      buttons_type b;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            tick_counter(req_reset_pressed, req_inc_pressed, req_dec_pressed);
         if (req_valid && req_stall) begin
            // keep the request steady
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_ticks.size() > 0) begin
            b = pending_ticks.pop_front();
            req_valid <= 1'b1;
            req_reset_pressed <= b.rst;
            req_inc_pressed <= b.inc;
            req_dec_pressed <= b.dec;
            if (idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 14);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result monitor and receiver stall generation
   always @(posedge clock) begin
      digit_mode_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_digit_mode.size() == 0) begin
               note_failure($sformatf("unexpected result digit=%0d mode=%0d",
                                      rsp_digit, rsp_mode));
            end else begin
               want = expected_digit_mode.pop_front();
               checked++;
               if (rsp_digit !== want.digit || rsp_mode !== want.mode)
                  note_failure($sformatf(
                     "result %0d: expected digit=%0d mode=%0d, got digit=%0d mode=%0d",
                     checked, want.digit, want.mode, rsp_digit, rsp_mode));
               else
                  mode_seen[rsp_mode]++;
            end
         end
         if (rcv_hold) begin
            rsp_stall <= 1'b1;
         end else if (rcv_gap > 0) begin
            rcv_gap--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rcv_gap = $urandom_range(0, 13);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Register write: setup cycle then access cycle, ends on a falling edge
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [TICKS_W-1:0] val);
      logic [CSR_DATA_W-1:0] data;
      data = {16'($urandom), val};
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (addr[3:2])
         CSR_IDLE:   cfg_idle = data[TICKS_W-1:0];
         CSR_HOLD:   cfg_hold = data[TICKS_W-1:0];
         CSR_REPEAT: cfg_step = data[TICKS_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_timing(input logic [TICKS_W-1:0] idle_t, input logic [TICKS_W-1:0] hold_t,
                             input logic [TICKS_W-1:0] step_t);
      csr_write({CSR_IDLE, 2'b00}, idle_t);
      csr_write({CSR_HOLD, 2'b00}, hold_t);
      csr_write({CSR_REPEAT, 2'b00}, step_t);
      settings_count++;
   endtask

   task automatic queue_tick(input logic rst, input logic inc, input logic dec);
      buttons_type b;
      b.rst = rst;
      b.inc = inc;
      b.dec = dec;
      pending_ticks.push_back(b);
      phase_count++;
   endtask

   // Wait until every request is taken and every result checked
   task automatic wait_drained();
      while (pending_ticks.size() != 0 || req_valid || expected_digit_mode.size() != 0)
         @(negedge clock);
   endtask

   // One random button sequence sized from the current timing
   task automatic queue_sequence();
      int kind;
      int lim;
      int n;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2, 3: begin
            // hold one button for a random run of ticks, at most hold + 3 * repeat + 2, capped at 60
            lim = int'(cfg_hold) + 3 * int'(cfg_step) + 2;
            if (lim > 60) lim = 60;
            n = $urandom_range(1, lim);
            repeat (n) queue_tick(1'b0, kind < 2, kind >= 2);
            queue_tick(1'b0, 1'b0, 1'b0);
         end
         4: begin
            repeat ($urandom_range(1, 2)) queue_tick(1'b1, 1'b0, 1'b0);
            queue_tick(1'b0, 1'b0, 1'b0);
         end
         5, 6, 7: begin
            // no activity for a random run of ticks, which may reach the sleep countdown
            lim = int'(cfg_idle) + 6 * int'(cfg_step) + 2;
            if (lim > 80) lim = 80;
            n = $urandom_range(1, lim);
            repeat (n) queue_tick(1'b0, 1'b0, 1'b0);
         end
         default: begin
            repeat ($urandom_range(1, 6))
               queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
         end
      endcase
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset press, reset racing the idle expiry, holds, multi-press
      set_timing(16'd3, 16'd2, 16'd1);
      csr_write(CSR_UNUSED_ADDR, 16'($urandom));
      queue_tick(1'b1, 1'b0, 1'b0);
      queue_tick(1'b0, 1'b0, 1'b0);
      queue_tick(1'b0, 1'b0, 1'b0);
      queue_tick(1'b0, 1'b0, 1'b0);
      queue_tick(1'b1, 1'b0, 1'b0);
      queue_tick(1'b0, 1'b0, 1'b0);
      repeat (4) queue_tick(1'b0, 1'b1, 1'b0);
      queue_tick(1'b0, 1'b0, 1'b0);
      repeat (5) queue_tick(1'b0, 1'b0, 1'b1);
      queue_tick(1'b0, 1'b0, 1'b0);
      queue_tick(1'b0, 1'b1, 1'b1);
      queue_tick(1'b1, 1'b1, 1'b1);
      queue_tick(1'b0, 1'b0, 1'b0);
      queue_tick(1'b1, 1'b1, 1'b0);
      repeat (4) queue_tick(1'b0, 1'b0, 1'b0);
      wait_drained();

      // Random phases over several timing settings
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: set_timing(16'd1, 16'd1, 16'd1);
            1: set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
            2: set_timing(16'd0, 16'd0, 16'd0);
            3: set_timing(16'd0, 16'($urandom_range(1, 6)), 16'($urandom_range(1, 4)));
            4: set_timing(16'($urandom), 16'($urandom), 16'($urandom));
            default: set_timing(16'($urandom_range(1, 30)), 16'($urandom_range(1, 15)),
                                16'($urandom_range(1, 6)));
         endcase
         if (p == NUM_PHASES - 1) idle_on = 1'b0;
         phase_count = 0;
         while (phase_count < ((p == 1) ? 60 : PHASE_TICKS)) queue_sequence();
         if (p == 5) begin
            // long receiver hold-off while requests keep coming
            rcv_hold = 1'b1;
            repeat (150) @(negedge clock);
            rcv_hold = 1'b0;
         end
         wait_drained();
      end

      repeat (20) @(negedge clock);
      $display("Checked %0d tick results over %0d timing settings,", checked, settings_count);
      $display("zero and full-scale timers included; modes seen: released %0d, sleep %0d,",
               mode_seen[0], mode_seen[1]);
      $display("reset %0d, inc %0d, dec %0d, inc long %0d, dec long %0d",
               mode_seen[2], mode_seen[3], mode_seen[4], mode_seen[5], mode_seen[6]);
      if (fail_count == 0 && expected_digit_mode.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("Timeout with %0d results outstanding", expected_digit_mode.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
